FILE: src/blockwise_delta_quantizer_codec_core_defines.svh
// Assertion macros shared by the codec RTL files.
`ifndef BLOCKWISE_DELTA_QUANTIZER_CODEC_CORE_DEFINES_SVH
`define BLOCKWISE_DELTA_QUANTIZER_CODEC_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define BDQ_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("codec assertion failed");
`define BDQ_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("codec forbidden condition");
`else
`define BDQ_ASSERT(lbl, clk, rst_n, prop)
`define BDQ_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

FILE: src/bdq_pkg.sv
// Shared constants, codes and types of the delta quantizer codec.
package bdq_pkg;

  localparam int unsigned BLOCK_LENGTH = 256;
  localparam int unsigned POS_W = $clog2(BLOCK_LENGTH);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(BLOCK_LENGTH - 1);

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CODE_W = 16;
  localparam int unsigned QUANT_W = 34;
  localparam int unsigned PROD_W = 65;
  localparam int unsigned TERM_W = 49;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);

  localparam logic signed [CODE_W-1:0] CODE_MIN = 16'sh8000;
  localparam logic signed [CODE_W-1:0] CODE_MAX = 16'sh7fff;
  localparam logic signed [DATA_W-1:0] DATA_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] DATA_MAX = 32'sh7fff_ffff;
  localparam logic [2*DATA_W-1:0] ROUND_HALF = 64'h0000_0000_8000_0000;

  localparam logic [DATA_W-1:0] INV_STEP_RESET = 32'd327680000;
  localparam logic [DATA_W-1:0] STEP_SIZE_RESET = 32'd13;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE,
    CFG_INV_STEP,
    CFG_STEP_SIZE
  } cfg_index_e;

  typedef enum logic {
    MODE_COMPRESS,
    MODE_DECOMPRESS
  } mode_e;

  typedef struct packed {
    mode_e                     mode;
    logic                      start;
    logic                      neg;
    logic                      clipped;
    logic signed [DATA_W:0]    operand;
  } job_t;

endpackage

FILE: src/bdq_front.sv
// Front end: accepts samples, tracks the block position and prepares multiplier operands.
module bdq_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  logic [31:0]    data_i,
  input  logic           array_start_i,
  input  bdq_pkg::mode_e mode_i,
  input  logic           full_i,
  output logic           push_o,
  output bdq_pkg::job_t  job_o
);
  import bdq_pkg::*;

  logic [POS_W-1:0] pos_q, pos_d, pos_cur;
  logic accept;
  logic signed [DATA_W-1:0] x;
  logic [DATA_W-1:0] mag;
  job_t job;

  assign ready_o = !full_i;
  assign accept = valid_i && !full_i;
  assign x = $signed(data_i);

  always_comb begin
    pos_cur = array_start_i ? '0 : pos_q;
    pos_d = pos_q;
    if (accept) begin
      pos_d = (pos_cur == POS_LAST) ? '0 : pos_cur + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  always_comb begin
    mag = x[DATA_W-1] ? (DATA_W'(0) - data_i) : data_i;
    job.mode = mode_i;
    job.start = (pos_cur == '0);
    job.neg = 1'b0;
    job.clipped = 1'b0;
    job.operand = '0;
    case (mode_i)
      MODE_COMPRESS: begin
        job.neg = x[DATA_W-1];
        job.operand = $signed({1'b0, mag});
      end
      MODE_DECOMPRESS: begin
        if (x < DATA_W'(CODE_MIN)) begin
          job.operand = (DATA_W+1)'(CODE_MIN);
          job.clipped = 1'b1;
        end else if (x > DATA_W'(CODE_MAX)) begin
          job.operand = (DATA_W+1)'(CODE_MAX);
          job.clipped = 1'b1;
        end else begin
          job.operand = (DATA_W+1)'(x);
        end
      end
      default: begin
        job.operand = '0;
      end
    endcase
  end

  assign push_o = accept;
  assign job_o = job;

endmodule

FILE: src/bdq_queue.sv
// Short job queue between the front end and the arithmetic back end.
`include "blockwise_delta_quantizer_codec_core_defines.svh"
module bdq_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  bdq_pkg::job_t job_i,
  output logic          full_o,
  input  logic          rd_i,
  output logic          empty_o,
  output bdq_pkg::job_t job_o
);
  import bdq_pkg::*;

  job_t mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0] cnt_q, cnt_d;

  assign full_o = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign job_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = rd_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d = cnt_q;
    if (wr_i && !rd_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_i && !wr_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  `BDQ_ASSERT_NEVER(a_no_push_full, clk_i, rst_ni, wr_i && full_o)
  `BDQ_ASSERT_NEVER(a_no_pop_empty, clk_i, rst_ni, rd_i && empty_o)

endmodule

FILE: src/bdq_back.sv
// Back end: multiply, round, delta or accumulate with saturation, and the output register.
`include "blockwise_delta_quantizer_codec_core_defines.svh"
module bdq_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  bdq_pkg::job_t job_i,
  output logic          rd_o,
  input  logic [31:0]   inverse_step_i,
  input  logic [31:0]   step_size_i,
  output logic          valid_o,
  input  logic          ready_i,
  output logic [31:0]   value_o,
  output logic          saturated_o
);
  import bdq_pkg::*;

  logic en;

  logic a_valid_q, a_start_q, a_neg_q, a_clip_q;
  mode_e a_mode_q;
  logic [PROD_W-1:0] prod_q;
  logic signed [DATA_W:0] mul_b;
  logic signed [2*DATA_W+1:0] mul_full;

  logic b_valid_q, b_start_q, b_clip_q;
  mode_e b_mode_q;
  logic signed [TERM_W-1:0] val_q, val_d;
  logic [2*DATA_W-1:0] rnd;
  logic [QUANT_W-1:0] qext, qsig;

  logic signed [QUANT_W-1:0] prevq_q, prevq_d, prevq;
  logic signed [DATA_W-1:0] prevr_q, prevr_d, prevr;
  logic signed [QUANT_W:0] diff;
  logic signed [TERM_W:0] sum;
  logic out_valid_q;
  logic [DATA_W-1:0] out_data_q, out_data_d;
  logic out_sat_q, out_sat_d;

  assign en = !out_valid_q || ready_i;
  assign rd_o = en && !empty_i;

  assign mul_b = $signed({1'b0, (job_i.mode == MODE_DECOMPRESS) ? step_size_i : inverse_step_i});
  assign mul_full = $signed(job_i.operand) * mul_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      prevq_q <= '0;
      prevr_q <= '0;
    end else if (en) begin
      a_valid_q <= rd_o;
      b_valid_q <= a_valid_q;
      out_valid_q <= b_valid_q;
      prevq_q <= prevq_d;
      prevr_q <= prevr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_mode_q <= job_i.mode;
      a_start_q <= job_i.start;
      a_neg_q <= job_i.neg;
      a_clip_q <= job_i.clipped;
      prod_q <= mul_full[PROD_W-1:0];
      b_mode_q <= a_mode_q;
      b_start_q <= a_start_q;
      b_clip_q <= a_clip_q;
      val_q <= val_d;
      out_data_q <= out_data_d;
      out_sat_q <= out_sat_d;
    end
  end

  always_comb begin
    rnd = prod_q[2*DATA_W-1:0] + ROUND_HALF;
    qext = {2'b00, rnd[2*DATA_W-1:DATA_W]};
    qsig = a_neg_q ? (QUANT_W'(0) - qext) : qext;
    if (a_mode_q == MODE_COMPRESS) begin
      val_d = TERM_W'($signed(qsig));
    end else begin
      val_d = $signed(prod_q[TERM_W-1:0]);
    end
  end

  always_comb begin
    prevq = b_start_q ? '0 : prevq_q;
    prevr = b_start_q ? '0 : prevr_q;
    diff = (QUANT_W+1)'($signed(val_q[QUANT_W-1:0])) - (QUANT_W+1)'(prevq);
    sum = (TERM_W+1)'(val_q) + (TERM_W+1)'(prevr);
    prevq_d = prevq_q;
    prevr_d = prevr_q;
    out_data_d = out_data_q;
    out_sat_d = out_sat_q;
    if (b_valid_q) begin
      out_sat_d = b_clip_q;
      case (b_mode_q)
        MODE_COMPRESS: begin
          prevq_d = $signed(val_q[QUANT_W-1:0]);
          if (diff < (QUANT_W+1)'(CODE_MIN)) begin
            out_data_d = DATA_W'(CODE_MIN);
            out_sat_d = 1'b1;
          end else if (diff > (QUANT_W+1)'(CODE_MAX)) begin
            out_data_d = DATA_W'(CODE_MAX);
            out_sat_d = 1'b1;
          end else begin
            out_data_d = DATA_W'($signed(diff[CODE_W-1:0]));
          end
        end
        MODE_DECOMPRESS: begin
          if (sum < (TERM_W+1)'(DATA_MIN)) begin
            out_data_d = DATA_MIN;
            out_sat_d = 1'b1;
          end else if (sum > (TERM_W+1)'(DATA_MAX)) begin
            out_data_d = DATA_MAX;
            out_sat_d = 1'b1;
          end else begin
            out_data_d = sum[DATA_W-1:0];
          end
          prevr_d = $signed(out_data_d);
        end
        default: begin
          out_sat_d = 1'b0;
        end
      endcase
    end
  end

  assign valid_o = out_valid_q;
  assign value_o = out_data_q;
  assign saturated_o = out_sat_q;

  `BDQ_ASSERT(a_state_held, clk_i, rst_ni, (out_valid_q && !ready_i) |=> $stable(prevq_q) && $stable(prevr_q))
  `BDQ_ASSERT(a_pop_fills, clk_i, rst_ni, rd_o |=> a_valid_q)
  `BDQ_ASSERT(a_b_held, clk_i, rst_ni, (b_valid_q && !en) |=> b_valid_q)

endmodule

FILE: src/blockwise_delta_quantizer_codec_core.sv
// Top level of the block-wise delta quantizer codec.
// Input beats arrive on s_axis: tdata holds one Q16.16 sample (compress) or one code
// (decompress); tuser marks the first beat of a new array, which restarts the block
// position. Results leave on m_axis: tdata holds the sign-extended code or the
// reconstructed Q16.16 sample; tuser is set when a value was clipped.
// The cfg channel writes mode, inverse step and step size by index and is always ready.
// Registers are to be written only while no beat is in flight; the block does not
// enforce this. Throughput is one beat per cycle while m_axis accepts results. An
// accepted beat passes through the job queue, the multiplier stage and the rounding
// stage, with the delta or accumulation done into the output register.
// When m_axis stalls, the back pipeline holds and the four-entry job queue fills; only
// then does s_axis_tready drop. Reset clears the block position, both running
// previous values and the queue, and loads the default register values.
module blockwise_delta_quantizer_codec_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value_in
  input  logic [0:0]  s_axis_tuser,   // [0] array_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] value_out
  output logic [0:0]  m_axis_tuser,   // [0] saturated
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [bdq_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import bdq_pkg::*;

  mode_e mode_q;
  logic [DATA_W-1:0] inv_step_q, step_size_q;
  logic push, full, empty, pop;
  job_t front_job, queue_job;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_COMPRESS;
      inv_step_q <= INV_STEP_RESET;
      step_size_q <= STEP_SIZE_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_MODE: mode_q <= mode_e'(cfg_data_i[0]);
        CFG_INV_STEP: inv_step_q <= cfg_data_i;
        CFG_STEP_SIZE: step_size_q <= cfg_data_i;
        default: mode_q <= mode_q;
      endcase
    end
  end

  bdq_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (s_axis_tvalid),
    .ready_o       (s_axis_tready),
    .data_i        (s_axis_tdata),
    .array_start_i (s_axis_tuser[0]),
    .mode_i        (mode_q),
    .full_i        (full),
    .push_o        (push),
    .job_o         (front_job)
  );

  bdq_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (push),
    .job_i   (front_job),
    .full_o  (full),
    .rd_i    (pop),
    .empty_o (empty),
    .job_o   (queue_job)
  );

  bdq_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (empty),
    .job_i          (queue_job),
    .rd_o           (pop),
    .inverse_step_i (inv_step_q),
    .step_size_i    (step_size_q),
    .valid_o        (m_axis_tvalid),
    .ready_i        (m_axis_tready),
    .value_o        (m_axis_tdata),
    .saturated_o    (m_axis_tuser[0])
  );

endmodule
